// ----- rtl/tea_pkg.sv -----
// Shared types and codes for the two-ended arena allocator.
// Operation, status and register index codes, and the calc-to-core control struct.
// No dependencies.
package tea_pkg;

   // operation codes
   localparam logic [1:0] OP_ALLOC_LOW  = 2'd0;
   localparam logic [1:0] OP_ALLOC_HIGH = 2'd1;
   localparam logic [1:0] OP_SET_LOW    = 2'd2;
   localparam logic [1:0] OP_SET_HIGH   = 2'd3;

   // status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_ALIGN = 3'd1;
   localparam logic [2:0] ST_UNSET = 3'd2;
   localparam logic [2:0] ST_ROOM  = 3'd3;
   localparam logic [2:0] ST_BOUND = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_REGION0_START = 2'd0;
   localparam logic [1:0] CSR_REGION0_END   = 2'd1;
   localparam logic [1:0] CSR_REGION1_START = 2'd2;
   localparam logic [1:0] CSR_REGION1_END   = 2'd3;

   // outcome of one transaction, from the calc stage to the pointer file
   typedef struct packed {
      logic [2:0] status;
      logic       wr_low;
      logic       wr_high;
   } calc_ctl_type;

endpackage

// ----- rtl/tea_csr.sv -----
// Region bound registers of the two-ended arena allocator.
// Written through the plain csr port, read back for the selected region.
// Depends on tea_pkg.
module tea_csr
   import tea_pkg::*;
#(
   parameter int ADDR_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   input  logic                  region_sel,
   output logic [ADDR_WIDTH-1:0] region_start,
   output logic [ADDR_WIDTH-1:0] region_end
);

   localparam int CW = (ADDR_WIDTH > 32) ? ADDR_WIDTH : 32;

   logic [ADDR_WIDTH-1:0] start_ff [2];
   logic [ADDR_WIDTH-1:0] end_ff   [2];
   logic [CW-1:0]         wdata_w;
   logic [ADDR_WIDTH-1:0] wdata_in;

   // value stored masked to the address width
   assign wdata_w  = CW'(csr_wdata);
   assign wdata_in = wdata_w[ADDR_WIDTH-1:0];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff[0] <= '0;
         start_ff[1] <= '0;
         end_ff[0]   <= '0;
         end_ff[1]   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_REGION0_START: start_ff[0] <= wdata_in;
            CSR_REGION0_END:   end_ff[0]   <= wdata_in;
            CSR_REGION1_START: start_ff[1] <= wdata_in;
            CSR_REGION1_END:   end_ff[1]   <= wdata_in;
            default: ;
         endcase
      end
   end

   // bounds of the selected region
   assign region_start = start_ff[region_sel];
   assign region_end   = end_ff[region_sel];

endmodule

// ----- rtl/tea_calc.sv -----
// Single-pass calculation for one allocator transaction.
// Alignment, room checks and the new pointer value; purely combinational.
// Depends on tea_pkg.
module tea_calc
   import tea_pkg::*;
#(
   parameter int ADDR_WIDTH = 32
) (
   input  logic [1:0]            operation,
   input  logic [31:0]           request_size,
   input  logic [31:0]           align_bytes,
   input  logic [31:0]           new_pointer,
   input  logic [ADDR_WIDTH-1:0] low_ptr,
   input  logic [ADDR_WIDTH-1:0] high_ptr,
   input  logic [ADDR_WIDTH-1:0] region_start,
   input  logic [ADDR_WIDTH-1:0] region_end,
   output calc_ctl_type          ctl,
   output logic [ADDR_WIDTH-1:0] ptr_new,
   output logic [ADDR_WIDTH-1:0] block_addr
);

   // compute width covers both the address and the 32-bit request fields
   localparam int            CW    = (ADDR_WIDTH > 32) ? ADDR_WIDTH : 32;
   localparam logic [CW-1:0] AMASK = CW'({ADDR_WIDTH{1'b1}});

   logic [CW-1:0] lo_w, hi_w, sz_w, al_w, ad_w, rs_w, re_w;
   logic [CW-1:0] mask, pad, span, start_lo, blk_end, epad, low_next;
   logic [CW-1:0] top, start_hi;
   logic          pow2, arena_bad, addr_out;
   logic          low_fits, high_fits;

   assign lo_w = CW'(low_ptr);
   assign hi_w = CW'(high_ptr);
   assign sz_w = CW'(request_size);
   assign al_w = CW'(align_bytes);
   assign ad_w = CW'(new_pointer);
   assign rs_w = CW'(region_start);
   assign re_w = CW'(region_end);

   // request checks
   assign pow2      = (align_bytes != '0) && ((align_bytes & (align_bytes - 32'd1)) == '0);
   assign arena_bad = (low_ptr == '0) || (low_ptr > high_ptr);
   assign addr_out  = ((ad_w & ~AMASK) != '0) || (ad_w < rs_w) || (ad_w > re_w);
   assign mask      = (al_w - CW'(1)) & AMASK;

   // allocate low: pad the start up, reserve, round the end up
   assign pad      = (CW'(0) - lo_w) & mask;
   assign span     = hi_w - lo_w;
   assign start_lo = lo_w + pad;
   assign blk_end  = start_lo + sz_w;
   assign epad     = (CW'(0) - blk_end) & mask;
   assign low_next = blk_end + epad;
   assign low_fits = (pad <= span) && (sz_w <= span - pad) && (epad <= hi_w - blk_end);

   // allocate high: round the top down, carve the aligned block below it
   assign top       = hi_w & ~mask;
   assign start_hi  = (top - sz_w) & ~mask;
   assign high_fits = (top >= lo_w) && (sz_w <= top - lo_w) && (start_hi >= lo_w);

   // outcome selection
   always_comb begin
      ctl.status  = ST_OK;
      ctl.wr_low  = 1'b0;
      ctl.wr_high = 1'b0;
      ptr_new     = ad_w[ADDR_WIDTH-1:0];
      block_addr  = '0;
      if (operation == OP_SET_LOW || operation == OP_SET_HIGH) begin
         if (addr_out) begin
            ctl.status = ST_BOUND;
         end else begin
            ctl.wr_low  = (operation == OP_SET_LOW);
            ctl.wr_high = (operation == OP_SET_HIGH);
         end
      end else if (!pow2) begin
         ctl.status = ST_ALIGN;
      end else if (arena_bad) begin
         ctl.status = ST_UNSET;
      end else if (operation == OP_ALLOC_LOW) begin
         if (low_fits) begin
            ctl.wr_low = 1'b1;
            ptr_new    = low_next[ADDR_WIDTH-1:0];
            block_addr = start_lo[ADDR_WIDTH-1:0];
         end else begin
            ctl.status = ST_ROOM;
         end
      end else begin
         if (high_fits) begin
            ctl.wr_high = 1'b1;
            ptr_new     = start_hi[ADDR_WIDTH-1:0];
            block_addr  = start_hi[ADDR_WIDTH-1:0];
         end else begin
            ctl.status = ST_ROOM;
         end
      end
   end

endmodule

// ----- rtl/two_ended_arena_allocator_core.sv -----
// Top level of the two-ended arena allocator: request register, pointer file,
// result register. Depends on tea_pkg, tea_csr and tea_calc.
//
//   channel   handshake                ports
//   request   start, busy              req_operation .. req_new_pointer
//   response  rsp_strobe (one cycle)   rsp_status .. rsp_arena_high_now
//   config    csr_write                csr_index, csr_wdata
//
// One transaction per cycle; the response passes the request register and then
// the response register. The pointer read-modify-write through tea_calc is
// combinational, so a transaction sees the pointers left by the one before it.
// Synchronous reset clears pointers, bounds and the strobe.
// busy stays low; the receiver cannot stall, each response shows for one cycle.
module two_ended_arena_allocator_core
   import tea_pkg::*;
#(
   parameter int ADDR_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic        req_region,
   input  logic [31:0] req_request_size,
   input  logic [31:0] req_align_bytes,
   input  logic [31:0] req_new_pointer,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_block_address,
   output logic [31:0] rsp_arena_low_now,
   output logic [31:0] rsp_arena_high_now,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int CW = (ADDR_WIDTH > 32) ? ADDR_WIDTH : 32;

   logic                  req_valid_ff;
   logic [1:0]            req_operation_ff;
   logic                  req_region_ff;
   logic [31:0]           req_request_size_ff;
   logic [31:0]           req_align_bytes_ff;
   logic [31:0]           req_new_pointer_ff;

   logic [ADDR_WIDTH-1:0] low_ptr_ff  [2];
   logic [ADDR_WIDTH-1:0] high_ptr_ff [2];

   logic                  rsp_strobe_ff;
   logic [2:0]            rsp_status_ff;
   logic [31:0]           rsp_block_ff;
   logic [31:0]           rsp_low_ff;
   logic [31:0]           rsp_high_ff;

   logic [ADDR_WIDTH-1:0] region_start, region_end;
   logic [ADDR_WIDTH-1:0] cur_low, cur_high, ptr_new, block_addr;
   logic [ADDR_WIDTH-1:0] low_in, high_in;
   logic [CW-1:0]         low_w, high_w, block_w;
   calc_ctl_type          ctl;

   assign busy = 1'b0;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_operation_ff    <= req_operation;
         req_region_ff       <= req_region;
         req_request_size_ff <= req_request_size;
         req_align_bytes_ff  <= req_align_bytes;
         req_new_pointer_ff  <= req_new_pointer;
      end
   end

   // region bounds
   tea_csr #(
      .ADDR_WIDTH(ADDR_WIDTH)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .region_sel  (req_region_ff),
      .region_start(region_start),
      .region_end  (region_end)
   );

   assign cur_low  = low_ptr_ff[req_region_ff];
   assign cur_high = high_ptr_ff[req_region_ff];

   // transaction calculation
   tea_calc #(
      .ADDR_WIDTH(ADDR_WIDTH)
   ) u_calc (
      .operation   (req_operation_ff),
      .request_size(req_request_size_ff),
      .align_bytes (req_align_bytes_ff),
      .new_pointer (req_new_pointer_ff),
      .low_ptr     (cur_low),
      .high_ptr    (cur_high),
      .region_start(region_start),
      .region_end  (region_end),
      .ctl         (ctl),
      .ptr_new     (ptr_new),
      .block_addr  (block_addr)
   );

   assign low_in  = ctl.wr_low  ? ptr_new : cur_low;
   assign high_in = ctl.wr_high ? ptr_new : cur_high;

   // pointer file
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ptr_ff[0]  <= '0;
         low_ptr_ff[1]  <= '0;
         high_ptr_ff[0] <= '0;
         high_ptr_ff[1] <= '0;
      end else if (req_valid_ff) begin
         low_ptr_ff[req_region_ff]  <= low_in;
         high_ptr_ff[req_region_ff] <= high_in;
      end
   end

   // response register, pointers shown in their low 32 bits
   assign low_w   = CW'(low_in);
   assign high_w  = CW'(high_in);
   assign block_w = CW'(block_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_status_ff <= ctl.status;
         rsp_block_ff  <= block_w[31:0];
         rsp_low_ff    <= low_w[31:0];
         rsp_high_ff   <= high_w[31:0];
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_block_address  = rsp_block_ff;
   assign rsp_arena_low_now  = rsp_low_ff;
   assign rsp_arena_high_now = rsp_high_ff;

`ifndef NO_ASSERTIONS
   // a response only follows a registered request
   a_strobe_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(req_valid_ff))
      else $error("response without a request");

   // pointers of region zero move only on a transaction
   a_ptr0_quiet: assert property (@(posedge clock) disable iff (reset)
      !($stable(low_ptr_ff[0]) && $stable(high_ptr_ff[0])) |-> $past(req_valid_ff))
      else $error("region zero pointers moved without a transaction");

   // pointers of region one move only on a transaction
   a_ptr1_quiet: assert property (@(posedge clock) disable iff (reset)
      !($stable(low_ptr_ff[1]) && $stable(high_ptr_ff[1])) |-> $past(req_valid_ff))
      else $error("region one pointers moved without a transaction");

   // a failed transaction reports no block
   a_fail_no_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_status_ff != ST_OK) |-> (rsp_block_ff == '0))
      else $error("failed transaction returned a block address");
`endif

endmodule
